// ----- rtl/core/stsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsp_pkg
// Shared constants and types for the stereo XY scope ring plotter.
// ----------------------------------------------------------------------------
package stsp_pkg;

  // Gain is unsigned Q4.12, deflections carry 8 fraction bits
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 12;
  localparam int XY_FRAC     = 8;
  localparam int RING_W      = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  // Register values after reset
  localparam int                RST_WIDTH  = 80;
  localparam int                RST_HEIGHT = 24;
  localparam logic [GAIN_W-1:0] RST_GAIN   = 16'd4096;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_GAIN   = 2'd2
  } cfg_reg_t;

  // Ring count unit status
  typedef struct packed {
    logic              busy;
    logic [RING_W-1:0] count;
  } ring_stat_t;

endpackage

// ----- rtl/core/stsp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsp_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module stsp_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);
  import stsp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_data = mem_r[rd_ptr_r];

  // Track fill level
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  // Store words
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/stsp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsp_front
// Accepts sample words, splits each sample into sign, magnitude and window
// half, and places the classified word in the queue.
// ----------------------------------------------------------------------------
module stsp_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int DIM_BITS    = 10
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_BITS-1:0]          in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0]          in_right_sample,
  input  logic                                   in_frame_last,
  input  logic [DIM_BITS-1:0]                    wnd_w,
  input  logic [DIM_BITS-1:0]                    wnd_h,
  input  logic                                   q_pop,
  output logic                                   q_not_empty,
  output logic [2*(1+SAMPLE_BITS+DIM_BITS):0]    q_head
);
  import stsp_pkg::*;

  typedef struct packed {
    logic                   xneg;
    logic [SAMPLE_BITS-1:0] xmag;
    logic [DIM_BITS-1:0]    xhalf;
    logic                   yneg;
    logic [SAMPLE_BITS-1:0] ymag;
    logic [DIM_BITS-1:0]    yhalf;
    logic                   last;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  entry_t entry;
  logic   full;
  logic   push;

  // Split a sample into sign and magnitude and pick the window half
  always_comb begin
    entry.xneg  = in_left_sample[SAMPLE_BITS-1];
    entry.xmag  = entry.xneg ? -in_left_sample : in_left_sample;
    entry.xhalf = entry.xneg ? (wnd_w >> 1) : (wnd_w - (wnd_w >> 1));
    entry.yneg  = in_right_sample[SAMPLE_BITS-1];
    entry.ymag  = entry.yneg ? -in_right_sample : in_right_sample;
    entry.yhalf = entry.yneg ? (wnd_h >> 1) : (wnd_h - (wnd_h >> 1));
    entry.last  = in_frame_last;
  end

  assign in_stall = full;
  assign push     = in_valid && !full;

  stsp_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (entry),
    .full      (full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_data (q_head)
  );

endmodule

// ----- rtl/core/stsp_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsp_ring
// Ring count unit: floor(sqrt(w^2 + 4h^2)), one root bit per cycle.
// ----------------------------------------------------------------------------
module stsp_ring #(
  parameter int DIM_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIM_BITS-1:0]   wnd_w,
  input  logic [DIM_BITS-1:0]   wnd_h,
  output stsp_pkg::ring_stat_t  stat
);
  import stsp_pkg::*;

  localparam int RCW     = 2 * DIM_BITS + 3;
  localparam int RC_ROOT = DIM_BITS + 2;
  localparam logic [RCW-1:0] TOP_BIT = RCW'(1) << (2 * (RC_ROOT - 1));

  logic              busy_r;
  logic [RCW-1:0]    v_r;
  logic [RCW-1:0]    root_r;
  logic [RCW-1:0]    bit_r;
  logic [RING_W-1:0] count_r;
  logic [RCW-1:0]    trial;
  logic [RCW-1:0]    root_nxt;
  logic [RCW-1:0]    v_nxt;

  assign stat.busy  = busy_r;
  assign stat.count = count_r;

  // One step of the digit-by-digit root
  always_comb begin
    trial = root_r + bit_r;
    if (v_r >= trial) begin
      v_nxt    = v_r - trial;
      root_nxt = (root_r >> 1) + bit_r;
    end else begin
      v_nxt    = v_r;
      root_nxt = root_r >> 1;
    end
  end

  // Hold busy from start until the last root bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (bit_r == RCW'(1))) begin
      busy_r <= 1'b0;
    end
  end

  // Load operand and iterate
  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= RCW'(wnd_w) * RCW'(wnd_w)
              + ((RCW'(wnd_h) * RCW'(wnd_h)) << 2);
      root_r <= '0;
      bit_r  <= TOP_BIT;
    end else if (busy_r) begin
      v_r    <= v_nxt;
      root_r <= root_nxt;
      bit_r  <= bit_r >> 2;
      if (bit_r == RCW'(1)) begin
        count_r <= RING_W'(root_nxt);
      end
    end
  end

endmodule

// ----- rtl/core/stsp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsp_back
// Arithmetic pipeline: deflection, placement, elliptic radius by a staged
// square root and ring index by a staged restoring remainder.
// ----------------------------------------------------------------------------
module stsp_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int DIM_BITS    = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_not_empty,
  input  logic [2*(1+SAMPLE_BITS+DIM_BITS):0] q_head,
  output logic                                q_pop,
  input  logic [DIM_BITS-1:0]                 wnd_w,
  input  logic [DIM_BITS-1:0]                 wnd_h,
  input  logic [stsp_pkg::GAIN_W-1:0]         scale_gain,
  input  stsp_pkg::ring_stat_t                ring_stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [DIM_BITS-1:0]                 out_row,
  output logic [DIM_BITS-1:0]                 out_column,
  output logic                                out_on_screen,
  output logic [stsp_pkg::RING_W-1:0]         out_ring_index,
  output logic                                out_frame_done
);
  import stsp_pkg::*;

  localparam int P1_W   = GAIN_W + SAMPLE_BITS;
  localparam int P2_W   = P1_W + DIM_BITS;
  localparam int SHIFT  = GAIN_FRAC + (SAMPLE_BITS - 1) - XY_FRAC;
  localparam int DEF_W  = P2_W - SHIFT;
  localparam int OFF_W  = DEF_W - XY_FRAC;
  localparam int SQ_W   = 2 * DEF_W + 3;
  localparam int ROOT_W = (SQ_W + 1) / 2;
  localparam int RAD_W  = ROOT_W - XY_FRAC;
  localparam int REM_W  = RING_W + 1;

  typedef struct packed {
    logic                   xneg;
    logic [SAMPLE_BITS-1:0] xmag;
    logic [DIM_BITS-1:0]    xhalf;
    logic                   yneg;
    logic [SAMPLE_BITS-1:0] ymag;
    logic [DIM_BITS-1:0]    yhalf;
    logic                   last;
  } entry_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] row;
    logic [DIM_BITS-1:0] col;
    logic                onscr;
    logic                last;
  } side_t;

  typedef struct packed {
    logic                on_win;
    logic [DIM_BITS-1:0] pos;
  } place_t;

  // Centre plus truncated deflection, clamped into the window
  function automatic place_t place(input logic [DIM_BITS-1:0] dim,
                                   input logic [DEF_W-1:0]    mag,
                                   input logic                neg);
    logic [OFF_W-1:0]    off;
    logic [DIM_BITS-1:0] dimh;
    logic [OFF_W:0]      sum;
    place_t              res;
    off  = mag[DEF_W-1:XY_FRAC];
    dimh = dim >> 1;
    sum  = (OFF_W + 1)'(dimh) + (OFF_W + 1)'(off);
    if (dim == '0) begin
      res.on_win = 1'b0;
      res.pos    = '0;
    end else if (neg) begin
      if ((OFF_W + 1)'(off) > (OFF_W + 1)'(dimh)) begin
        res.on_win = 1'b0;
        res.pos    = '0;
      end else begin
        res.on_win = 1'b1;
        res.pos    = dimh - DIM_BITS'(off);
      end
    end else if (sum >= (OFF_W + 1)'(dim)) begin
      res.on_win = 1'b0;
      res.pos    = dim - DIM_BITS'(1);
    end else begin
      res.on_win = 1'b1;
      res.pos    = DIM_BITS'(sum);
    end
    return res;
  endfunction

  entry_t head;
  logic   en;

  assign head  = q_head;
  assign en    = !out_valid || !out_stall;
  assign q_pop = en && q_not_empty;

  // Stage 1: gain times magnitude
  logic                v1_r;
  logic [P1_W-1:0]     p1x_r, p1y_r;
  logic [DIM_BITS-1:0] xhalf1_r, yhalf1_r;
  logic                xneg1_r, yneg1_r, last1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1x_r    <= P1_W'(scale_gain) * P1_W'(head.xmag);
      p1y_r    <= P1_W'(scale_gain) * P1_W'(head.ymag);
      xhalf1_r <= head.xhalf;
      yhalf1_r <= head.yhalf;
      xneg1_r  <= head.xneg;
      yneg1_r  <= head.yneg;
      last1_r  <= head.last;
    end
  end

  // Stage 2: times window half, drop to 8 fraction bits
  logic             v2_r;
  logic [DEF_W-1:0] xm2_r, ym2_r;
  logic             xneg2_r, yneg2_r, last2_r;
  logic [P2_W-1:0]  p2x, p2y;

  assign p2x = P2_W'(p1x_r) * P2_W'(xhalf1_r);
  assign p2y = P2_W'(p1y_r) * P2_W'(yhalf1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xm2_r   <= DEF_W'(p2x >> SHIFT);
      ym2_r   <= DEF_W'(p2y >> SHIFT);
      xneg2_r <= xneg1_r;
      yneg2_r <= yneg1_r;
      last2_r <= last1_r;
    end
  end

  // Stage 3: squares and placement
  logic                 v3_r;
  logic [2*DEF_W-1:0]   xsq3_r, ysq3_r;
  side_t                side3_r;
  place_t               px, py;

  assign px = place(wnd_w, xm2_r, xneg2_r);
  assign py = place(wnd_h, ym2_r, yneg2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xsq3_r        <= (2 * DEF_W)'(xm2_r) * (2 * DEF_W)'(xm2_r);
      ysq3_r        <= (2 * DEF_W)'(ym2_r) * (2 * DEF_W)'(ym2_r);
      side3_r.row   <= py.pos;
      side3_r.col   <= px.pos;
      side3_r.onscr <= px.on_win && py.on_win;
      side3_r.last  <= last2_r;
    end
  end

  // Stage 4 and root stages: x^2 + 4y^2, then one root bit per stage
  logic            sval_r  [ROOT_W+1];
  logic [SQ_W-1:0] srem_r  [ROOT_W+1];
  logic [SQ_W-1:0] sroot_r [ROOT_W+1];
  side_t           sside_r [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sval_r[0] <= 1'b0;
    end else if (en) begin
      sval_r[0] <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      srem_r[0]  <= SQ_W'(xsq3_r) + (SQ_W'(ysq3_r) << 2);
      sroot_r[0] <= '0;
      sside_r[0] <= side3_r;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
    logic [SQ_W-1:0] trial;

    assign trial = sroot_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sval_r[k+1] <= 1'b0;
      end else if (en) begin
        sval_r[k+1] <= sval_r[k];
      end
    end

    // Keep the bit where the trial fits
    always_ff @(posedge clk) begin
      if (en) begin
        if (srem_r[k] >= trial) begin
          srem_r[k+1]  <= srem_r[k] - trial;
          sroot_r[k+1] <= (sroot_r[k] >> 1) + BIT;
        end else begin
          srem_r[k+1]  <= srem_r[k];
          sroot_r[k+1] <= sroot_r[k] >> 1;
        end
        sside_r[k+1] <= sside_r[k];
      end
    end
  end

  // Remainder stages: one radius bit per stage
  logic              mval_r  [RAD_W];
  logic [REM_W-1:0]  mrem_r  [RAD_W];
  logic [RAD_W-1:0]  mrad_r  [RAD_W];
  side_t             mside_r [RAD_W];
  logic [REM_W-1:0]  divisor;

  assign divisor = REM_W'(ring_stat.count);

  for (genvar j = 0; j < RAD_W; j++) begin : g_mod
    logic             val_i;
    logic [REM_W-1:0] rem_i;
    logic [RAD_W-1:0] rad_i;
    side_t            side_i;
    logic [REM_W-1:0] shifted;

    if (j == 0) begin : g_first
      assign val_i  = sval_r[ROOT_W];
      assign rem_i  = '0;
      assign rad_i  = RAD_W'(sroot_r[ROOT_W] >> XY_FRAC);
      assign side_i = sside_r[ROOT_W];
    end else begin : g_next
      assign val_i  = mval_r[j-1];
      assign rem_i  = mrem_r[j-1];
      assign rad_i  = mrad_r[j-1];
      assign side_i = mside_r[j-1];
    end

    assign shifted = {rem_i[RING_W-1:0], rad_i[RAD_W-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mval_r[j] <= 1'b0;
      end else if (en) begin
        mval_r[j] <= val_i;
      end
    end

    // Subtract the ring count where it fits
    always_ff @(posedge clk) begin
      if (en) begin
        mrem_r[j]  <= (shifted >= divisor) ? shifted - divisor : shifted;
        mrad_r[j]  <= rad_i << 1;
        mside_r[j] <= side_i;
      end
    end
  end

  // Output register
  logic              out_valid_r;
  logic [DIM_BITS-1:0] row_r, col_r;
  logic              onscr_r, last_r;
  logic [RING_W-1:0] ring_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mval_r[RAD_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r   <= mside_r[RAD_W-1].row;
      col_r   <= mside_r[RAD_W-1].col;
      onscr_r <= mside_r[RAD_W-1].onscr;
      last_r  <= mside_r[RAD_W-1].last;
      ring_r  <= (ring_stat.count == '0) ? '0 : mrem_r[RAD_W-1][RING_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row        = row_r;
  assign out_column     = col_r;
  assign out_on_screen  = onscr_r;
  assign out_ring_index = ring_r;
  assign out_frame_done = last_r;

endmodule

// ----- rtl/core/stereo_xy_scope_ring_plot.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_xy_scope_ring_plot
// Stereo XY scope plotter: one plot point and colour ring index per sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (left and right sample, frame_last) enter on in_valid/in_stall
//   and each gives exactly one output word on out_valid/out_stall: row and
//   column clamped into the window, an on-screen flag, the ring index and a
//   copy of frame_last.
//   Throughput is one word per cycle while the pipeline is not stalled.
//   out_valid rises once the accepted word has passed the queue, the gain,
//   window-half and square stages, the staged square root (one root bit per
//   stage) and the staged remainder (one radius bit per stage).
//   A two-word queue separates input from the pipeline, so in_stall rises
//   only once the receiver has stalled the pipeline and the queue is full;
//   while out_stall is high and out_valid is set the whole pipeline holds.
//   Registers are written on cfg_valid/cfg_ready. After reset and after each
//   write of width or height cfg_ready stays low while the ring count is
//   recomputed one bit a cycle.
//   Reset restores an 80 x 24 window, unity gain and empties the pipeline.
// ----------------------------------------------------------------------------
module stereo_xy_scope_ring_plot #(
  parameter int SAMPLE_BITS = 16,
  parameter int DIM_BITS    = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0]       in_right_sample,
  input  logic                                in_frame_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [DIM_BITS-1:0]                 out_row,
  output logic [DIM_BITS-1:0]                 out_column,
  output logic                                out_on_screen,
  output logic [stsp_pkg::RING_W-1:0]         out_ring_index,
  output logic                                out_frame_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stsp_pkg::GAIN_W-1:0]         cfg_data
);
  import stsp_pkg::*;

  localparam int Q_W = 2 * (1 + SAMPLE_BITS + DIM_BITS) + 1;

  logic [DIM_BITS-1:0] width_r;
  logic [DIM_BITS-1:0] height_r;
  logic [GAIN_W-1:0]   gain_r;
  logic                go_r;
  ring_stat_t          ring_stat;
  logic                q_pop;
  logic                q_not_empty;
  logic [Q_W-1:0]      q_head;

  assign cfg_ready = !go_r && !ring_stat.busy;

  // Write registers and request a ring count update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_BITS'(RST_WIDTH);
      height_r <= DIM_BITS'(RST_HEIGHT);
      gain_r   <= RST_GAIN;
      go_r     <= 1'b1;
    end else begin
      go_r <= cfg_valid && cfg_ready &&
              ((cfg_reg_t'(cfg_index) == CFG_WIDTH) || (cfg_reg_t'(cfg_index) == CFG_HEIGHT));
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_WIDTH: begin
            width_r <= cfg_data[DIM_BITS-1:0];
          end
          CFG_HEIGHT: begin
            height_r <= cfg_data[DIM_BITS-1:0];
          end
          CFG_GAIN: begin
            gain_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  stsp_ring #(
    .DIM_BITS (DIM_BITS)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .wnd_w (width_r),
    .wnd_h (height_r),
    .stat  (ring_stat)
  );

  stsp_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DIM_BITS    (DIM_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_frame_last   (in_frame_last),
    .wnd_w           (width_r),
    .wnd_h           (height_r),
    .q_pop           (q_pop),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head)
  );

  stsp_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DIM_BITS    (DIM_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .wnd_w          (width_r),
    .wnd_h          (height_r),
    .scale_gain     (gain_r),
    .ring_stat      (ring_stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row        (out_row),
    .out_column     (out_column),
    .out_on_screen  (out_on_screen),
    .out_ring_index (out_ring_index),
    .out_frame_done (out_frame_done)
  );

endmodule

// ----- rtl/core/stsp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsp_checker
// Port-level checks for the stereo XY scope ring plotter.
// ----------------------------------------------------------------------------
module stsp_checker #(
  parameter int DIM_BITS    = 10
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [DIM_BITS-1:0]            out_row,
  input logic [DIM_BITS-1:0]            out_column,
  input logic                           out_on_screen,
  input logic [stsp_pkg::RING_W-1:0]    out_ring_index,
  input logic                           out_frame_done,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [stsp_pkg::CFG_IDX_W-1:0] cfg_index
);
  import stsp_pkg::*;

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_column)
      && $stable(out_on_screen) && $stable(out_ring_index) && $stable(out_frame_done))
    else $error("stalled output word changed");

  // Drain the pipeline on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // Block configuration while the reset ring count is worked out
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !cfg_ready)
    else $error("configuration taken during ring count update after reset");

  // Block configuration after a window write
  a_window_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT)
      |=> !cfg_ready)
    else $error("configuration taken during ring count update");

endmodule

bind stereo_xy_scope_ring_plot stsp_checker #(
  .DIM_BITS    (DIM_BITS)
) u_stsp_checker (.*);
